FILE: design/tjt_pkg.sv
// ----------------------------------------------------------------------------
// tjt_pkg: types and constants of the timed job table
// beat structs, table entry, command and result codes
// ----------------------------------------------------------------------------
`default_nettype none

package tjt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_W       = 32;

    localparam logic [31:0] MIN_INTERVAL_RESET = 32'd60;
    localparam logic [31:0] TIME_FLOOR_RESET   = 32'd1577836800;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_POLL   = 2'd2;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_FIRED  = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_FLOOR   = 1'd1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] message_tag;
        logic        recurring;
        logic [31:0] period_s;
        logic [31:0] fire_at;
        logic [31:0] job_id;
        logic [31:0] now;
    } in_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic        ok;
        logic [31:0] out_id;
        logic [15:0] out_tag;
        logic        out_recurring;
        logic [31:0] out_interval;
        logic [31:0] out_fire_at;
        logic [31:0] out_last_fired;
        logic        last;
    } out_t;

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] tag;
        logic        periodic;
        logic [31:0] interval;
        logic [31:0] due_time;
        logic [31:0] last_fire;
        logic        fired;
    } entry_t;

endpackage

`default_nettype wire

FILE: design/timed_job_table.sv
// ----------------------------------------------------------------------------
// timed_job_table: compact table of one-shot and periodic timed jobs
// add, remove by id and poll items, walked one entry per cycle
// ----------------------------------------------------------------------------
//  channel   ports                           transfer
//  item      start, busy, item               start & !busy
//  result    strobe, result                  strobe, one cycle, no stall
//  config    cfg_we, cfg_index, cfg_data     cfg_we, write only
//
//  add: S_IDLE to S_ADD and back to idle, one result
//  remove: walks the jobs until the id matches or runs out, one result
//  poll: one beat per due job and a final beat, one entry per cycle
//  through the shared compare and due-sum unit; results cannot be held off
//  rst_n clears control, count, id counter and registers; table not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module timed_job_table
    import tjt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire in_t                  item,
    output logic                      strobe,
    output out_t                      result,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_REMOVE,
        S_POLL
    } state_t;

    state_t            state_reg, state_next;
    in_t               cmd_reg, cmd_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [31:0]       id_ctr_reg, id_ctr_next;
    logic [31:0]       min_ivl_reg, min_ivl_next;
    logic [31:0]       floor_reg, floor_next;
    logic              taken_reg, taken_next;
    out_t              res_reg, res_next;
    logic              strobe_reg, strobe_next;

    entry_t            jobs_reg [TABLE_DEPTH];

    entry_t            cur;
    entry_t            new_entry;
    logic [32:0]       next_fire;
    logic              due;
    logic              in_range;
    logic              accept;
    logic              do_add;
    logic              do_drop;
    logic              do_touch;
    logic [31:0]       id_inc;
    logic [31:0]       new_id;
    logic [31:0]       clamped_ivl;

    assign accept   = start && (state_reg == S_IDLE);
    assign busy     = (state_reg != S_IDLE);
    assign strobe   = strobe_reg;
    assign result   = res_reg;

    // shared unit: one entry read, one due sum, one compare per cycle
    assign cur       = jobs_reg[idx_reg[IDX_W-1:0]];
    assign in_range  = idx_reg < count_reg;
    assign next_fire = {1'b0, cur.last_fire} + {1'b0, cur.interval};
    assign due       = cur.periodic ? (!cur.fired || ({1'b0, cmd_reg.now} >= next_fire))
                                    : (cmd_reg.now >= cur.due_time);

    assign id_inc      = id_ctr_reg + 32'd1;
    assign new_id      = (id_inc == 32'd0) ? 32'd1 : id_inc;
    assign clamped_ivl = (cmd_reg.recurring && (cmd_reg.period_s < min_ivl_reg))
                         ? min_ivl_reg : cmd_reg.period_s;

    always_comb
    begin
        new_entry.id        = new_id;
        new_entry.tag       = cmd_reg.message_tag;
        new_entry.periodic  = cmd_reg.recurring;
        new_entry.interval  = clamped_ivl;
        new_entry.due_time  = cmd_reg.fire_at;
        new_entry.last_fire = 32'd0;
        new_entry.fired     = 1'b0;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        id_ctr_next  = id_ctr_reg;
        min_ivl_next = min_ivl_reg;
        floor_next   = floor_reg;
        taken_next   = taken_reg;
        res_next     = res_reg;
        strobe_next  = 1'b0;
        do_add       = 1'b0;
        do_drop      = 1'b0;
        do_touch     = 1'b0;

        if (cfg_we)
        begin
            if (cfg_index == REG_MIN_INTERVAL)
            begin
                min_ivl_next = cfg_data;
            end
            else if (cfg_index == REG_TIME_FLOOR)
            begin
                floor_next = cfg_data;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = item;
                    idx_next   = '0;
                    taken_next = (item.now >= floor_reg);
                    unique case (item.mode)
                        MODE_ADD:    state_next = S_ADD;
                        MODE_REMOVE: state_next = S_REMOVE;
                        MODE_POLL:   state_next = S_POLL;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD:
            begin
                res_next             = '0;
                res_next.result_kind = KIND_ADD;
                res_next.last        = 1'b1;
                strobe_next          = 1'b1;
                state_next           = S_IDLE;
                if ((cmd_reg.message_tag != 16'd0) &&
                    (count_reg < CNT_W'(TABLE_DEPTH)))
                begin
                    do_add          = 1'b1;
                    res_next.ok     = 1'b1;
                    res_next.out_id = new_id;
                    id_ctr_next     = new_id;
                    count_next      = count_reg + CNT_W'(1);
                end
            end
            S_REMOVE:
            begin
                if (!in_range)
                begin
                    res_next             = '0;
                    res_next.result_kind = KIND_REMOVE;
                    res_next.last        = 1'b1;
                    strobe_next          = 1'b1;
                    state_next           = S_IDLE;
                end
                else if (cur.id == cmd_reg.job_id)
                begin
                    do_drop              = 1'b1;
                    count_next           = count_reg - CNT_W'(1);
                    res_next             = '0;
                    res_next.result_kind = KIND_REMOVE;
                    res_next.ok          = 1'b1;
                    res_next.last        = 1'b1;
                    strobe_next          = 1'b1;
                    state_next           = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            S_POLL:
            begin
                if (!taken_reg || !in_range)
                begin
                    res_next             = '0;
                    res_next.result_kind = KIND_DONE;
                    res_next.ok          = taken_reg;
                    res_next.last        = 1'b1;
                    strobe_next          = 1'b1;
                    state_next           = S_IDLE;
                end
                else if (due)
                begin
                    res_next.result_kind    = KIND_FIRED;
                    res_next.ok             = 1'b1;
                    res_next.out_id         = cur.id;
                    res_next.out_tag        = cur.tag;
                    res_next.out_recurring  = cur.periodic;
                    res_next.out_interval   = cur.interval;
                    res_next.out_fire_at    = cur.due_time;
                    res_next.out_last_fired = cur.fired ? cur.last_fire : 32'd0;
                    res_next.last           = 1'b0;
                    strobe_next             = 1'b1;
                    if (cur.periodic)
                    begin
                        do_touch = 1'b1;
                        idx_next = idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        do_drop    = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            count_reg   <= '0;
            id_ctr_reg  <= '0;
            min_ivl_reg <= MIN_INTERVAL_RESET;
            floor_reg   <= TIME_FLOOR_RESET;
            taken_reg   <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            count_reg   <= count_next;
            id_ctr_reg  <= id_ctr_next;
            min_ivl_reg <= min_ivl_next;
            floor_reg   <= floor_next;
            taken_reg   <= taken_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
    end

    // job table: append, touch in place, or close the gap at idx
    always_ff @(posedge clk)
    begin
        if (do_add)
        begin
            jobs_reg[count_reg[IDX_W-1:0]] <= new_entry;
        end
        if (do_touch)
        begin
            jobs_reg[idx_reg[IDX_W-1:0]].last_fire <= cmd_reg.now;
            jobs_reg[idx_reg[IDX_W-1:0]].fired     <= 1'b1;
        end
        if (do_drop)
        begin
            for (int j = 0; j < TABLE_DEPTH - 1; j++)
            begin
                if (CNT_W'(j) >= idx_reg)
                begin
                    jobs_reg[j] <= jobs_reg[j + 1];
                end
            end
        end
    end

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last) |-> !busy)
        else $error("last beat while sequencer still busy");

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.last) |-> busy)
        else $error("non-final beat after sequencer went idle");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("job count above table depth");

    a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (result.result_kind == KIND_FIRED)) |-> !result.last)
        else $error("fired job beat marked last");

    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (result.result_kind == KIND_ADD) && result.ok) |-> (result.out_id != 32'd0))
        else $error("accepted add returned id zero");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && ((item.mode == MODE_ADD) || (item.mode == MODE_REMOVE) ||
                            (item.mode == MODE_POLL))) |=> busy)
        else $error("accepted command did not start the sequencer");

endmodule

`default_nettype wire

FILE: verif/timed_job_table_tb.sv
// ----------------------------------------------------------------------------
// timed_job_table_tb: self-checking bench for the timed job table
// drives add, remove and poll commands with random gaps, mirrors the job table
// in a scoreboard and checks every result beat in order, field by field
// ----------------------------------------------------------------------------
`default_nettype none

import tjt_pkg::*;

class job_table_mirror;

    entry_t      jobs[TABLE_DEPTH];
    int unsigned job_total;
    logic [31:0] next_id;
    logic [31:0] min_ivl;
    logic [31:0] time_floor;
    out_t        awaited[$];
    int unsigned errors;

    function new();
        job_total  = 0;
        next_id    = '0;
        min_ivl    = MIN_INTERVAL_RESET;
        time_floor = TIME_FLOOR_RESET;
        errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        if (idx == REG_MIN_INTERVAL)
            min_ivl = val;
        else if (idx == REG_TIME_FLOOR)
            time_floor = val;
    endfunction

    function out_t make_beat(logic [1:0] kind, logic ok, logic [31:0] id, logic [15:0] tag,
                             logic rec, logic [31:0] ivl, logic [31:0] fat,
                             logic [31:0] lf, logic last);
        out_t b;
        b.result_kind    = kind;
        b.ok             = ok;
        b.out_id         = id;
        b.out_tag        = tag;
        b.out_recurring  = rec;
        b.out_interval   = ivl;
        b.out_fire_at    = fat;
        b.out_last_fired = lf;
        b.last           = last;
        return b;
    endfunction

    function void add_beat(out_t b);
        awaited.insert(awaited.size(), b);
    endfunction

    function void drop(int idx);
        int j;
        for (j = idx; j + 1 < job_total; j++)
            jobs[j] = jobs[j + 1];
        job_total--;
    endfunction

    function void take_item(in_t it);
        logic [31:0] ivl;
        logic [32:0] next_due;
        logic [31:0] lf;
        bit          due;
        bit          found;
        int          i;
        case (it.mode)
            MODE_ADD:
            begin
                if (it.message_tag == '0 || job_total >= TABLE_DEPTH)
                begin
                    add_beat(make_beat(KIND_ADD, 1'b0, '0, '0, 1'b0, '0, '0, '0, 1'b1));
                end
                else
                begin
                    ivl = it.period_s;
                    if (it.recurring && ivl < min_ivl)
                        ivl = min_ivl;
                    next_id = next_id + 32'd1;
                    if (next_id == '0)
                        next_id = 32'd1;
                    jobs[job_total].id        = next_id;
                    jobs[job_total].tag       = it.message_tag;
                    jobs[job_total].periodic  = it.recurring;
                    jobs[job_total].interval  = ivl;
                    jobs[job_total].due_time  = it.fire_at;
                    jobs[job_total].last_fire = '0;
                    jobs[job_total].fired     = 1'b0;
                    job_total++;
                    add_beat(make_beat(KIND_ADD, 1'b1, next_id, '0, 1'b0, '0, '0, '0,
                                       1'b1));
                end
            end
            MODE_REMOVE:
            begin
                found = 0;
                for (i = 0; i < job_total && !found; i++)
                begin
                    if (jobs[i].id == it.job_id)
                    begin
                        drop(i);
                        found = 1;
                    end
                end
                add_beat(make_beat(KIND_REMOVE, found, '0, '0, 1'b0, '0, '0, '0, 1'b1));
            end
            MODE_POLL:
            begin
                if (it.now < time_floor)
                begin
                    add_beat(make_beat(KIND_DONE, 1'b0, '0, '0, 1'b0, '0, '0, '0, 1'b1));
                end
                else
                begin
                    i = 0;
                    while (i < job_total)
                    begin
                        if (jobs[i].periodic)
                        begin
                            next_due = {1'b0, jobs[i].last_fire} + {1'b0, jobs[i].interval};
                            due = !jobs[i].fired || ({1'b0, it.now} >= next_due);
                        end
                        else
                        begin
                            due = it.now >= jobs[i].due_time;
                        end
                        if (!due)
                        begin
                            i++;
                        end
                        else
                        begin
                            lf = jobs[i].fired ? jobs[i].last_fire : '0;
                            add_beat(make_beat(KIND_FIRED, 1'b1, jobs[i].id, jobs[i].tag,
                                               jobs[i].periodic, jobs[i].interval,
                                               jobs[i].due_time, lf, 1'b0));
                            if (jobs[i].periodic)
                            begin
                                jobs[i].last_fire = it.now;
                                jobs[i].fired     = 1'b1;
                                i++;
                            end
                            else
                            begin
                                drop(i);
                            end
                        end
                    end
                    add_beat(make_beat(KIND_DONE, 1'b1, '0, '0, 1'b0, '0, '0, '0, 1'b1));
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function void complain(string what, out_t want, out_t got);
        errors++;
        if (errors <= 10)
        begin
            $display("mismatch: %s", what);
            $display("  exp kind=%0d ok=%0d id=%h tag=%h rec=%0d ivl=%h fat=%h lf=%h last=%0d",
                     want.result_kind, want.ok, want.out_id, want.out_tag, want.out_recurring,
                     want.out_interval, want.out_fire_at, want.out_last_fired, want.last);
            $display("  got kind=%0d ok=%0d id=%h tag=%h rec=%0d ivl=%h fat=%h lf=%h last=%0d",
                     got.result_kind, got.ok, got.out_id, got.out_tag, got.out_recurring,
                     got.out_interval, got.out_fire_at, got.out_last_fired, got.last);
        end
    endfunction

    function void match_beat(out_t got);
        out_t want;
        if (awaited.size() == 0)
        begin
            complain("beat with nothing awaited", '0, got);
        end
        else
        begin
            want = awaited.pop_front();
            if (got.result_kind !== want.result_kind || got.ok !== want.ok ||
                got.out_id !== want.out_id || got.out_tag !== want.out_tag ||
                got.out_recurring !== want.out_recurring ||
                got.out_interval !== want.out_interval ||
                got.out_fire_at !== want.out_fire_at ||
                got.out_last_fired !== want.out_last_fired || got.last !== want.last)
                complain("result field", want, got);
        end
    endfunction

endclass

module timed_job_table_tb;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    in_t                  item;
    logic                 strobe;
    out_t                 result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    job_table_mirror table_mirror;
    int              burst_left;
    int              cycle_count;

    timed_job_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .strobe    (strobe),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            table_mirror.match_beat(result);
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [31:0] sat_add(logic [31:0] a, int unsigned b);
        logic [32:0] s;
        s = {1'b0, a} + 33'(b);
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic in_t make_item(logic [1:0] m, logic [15:0] tag, logic rec,
                                      logic [31:0] ivl, logic [31:0] fat,
                                      logic [31:0] jid, logic [31:0] now_s);
        in_t it;
        it.mode        = m;
        it.message_tag = tag;
        it.recurring   = rec;
        it.period_s    = ivl;
        it.fire_at     = fat;
        it.job_id      = jid;
        it.now         = now_s;
        return it;
    endfunction

    task automatic send_item(in_t beat_in);
        int gap;
        gap = (burst_left > 0) ? 0 : $urandom_range(0, 9);
        if (burst_left > 0)
            burst_left--;
        else if ($urandom_range(0, 11) == 0)
            burst_left = $urandom_range(8, 20);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= beat_in;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        table_mirror.take_item(beat_in);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (table_mirror.awaited.size() != 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 4) @(posedge clk);
    endtask

    task automatic write_regs(logic [31:0] min_val, logic [31:0] floor_val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_MIN_INTERVAL;
        cfg_data  <= min_val;
        @(posedge clk);
        table_mirror.write_reg(REG_MIN_INTERVAL, min_val);
        cfg_index <= REG_TIME_FLOOR;
        cfg_data  <= floor_val;
        @(posedge clk);
        table_mirror.write_reg(REG_TIME_FLOOR, floor_val);
        cfg_we <= 1'b0;
    endtask

    task automatic directed_items();
        logic [31:0] f0;
        f0 = TIME_FLOOR_RESET;
        send_item(make_item(MODE_ADD, 16'h0000, 1'b1, 32'd100, f0, '0, '0));
        send_item(make_item(MODE_ADD, 16'h0001, 1'b1, 32'd0, '0, '0, '0));
        send_item(make_item(MODE_ADD, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, '0, '0, '0));
        send_item(make_item(MODE_ADD, 16'h1234, 1'b0, 32'd5, f0 + 32'd100, '0, '0));
        send_item(make_item(MODE_ADD, 16'h8000, 1'b0, 32'd0, 32'd0, '0, '0));
        send_item(make_item(MODE_POLL, '0, 1'b0, '0, '0, '0, f0 - 32'd1));
        send_item(make_item(MODE_POLL, '0, 1'b0, '0, '0, '0, 32'd0));
        send_item(make_item(MODE_POLL, '0, 1'b0, '0, '0, '0, f0));
        send_item(make_item(MODE_POLL, '0, 1'b0, '0, '0, '0, f0 + 32'd59));
        send_item(make_item(MODE_POLL, '0, 1'b0, '0, '0, '0, f0 + 32'd60));
        send_item(make_item(MODE_POLL, '0, 1'b0, '0, '0, '0, 32'hFFFF_FFFF));
        send_item(make_item(MODE_REMOVE, '0, 1'b0, '0, '0, 32'd0, '0));
        send_item(make_item(MODE_REMOVE, '0, 1'b0, '0, '0, 32'hFFFF_FFFF, '0));
        send_item(make_item(MODE_REMOVE, '0, 1'b0, '0, '0, 32'd2, '0));
        send_item(make_item(MODE_REMOVE, '0, 1'b0, '0, '0, 32'd2, '0));
        send_item(make_item(MODE_UNUSED, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(MODE_POLL, '0, 1'b0, '0, '0, '0, 32'hFFFF_FFFF));
        send_item(make_item(MODE_REMOVE, '0, 1'b0, '0, '0, 32'd1, '0));
        send_item(make_item(MODE_POLL, '0, 1'b0, '0, '0, '0, f0));
        send_item(make_item(MODE_ADD, 16'h0007, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0));
        send_item(make_item(MODE_POLL, '0, 1'b0, '0, '0, '0, 32'hFFFF_FFFE));
        send_item(make_item(MODE_REMOVE, '0, 1'b0, '0, '0, 32'd5, '0));
    endtask

    task automatic random_items(int add_pct, int rm_pct, int count);
        in_t         it;
        logic [31:0] t;
        logic [31:0] floor_now;
        int          r;
        int          n;
        floor_now = table_mirror.time_floor;
        t = (floor_now > 32'hFFFF_0000) ? 32'hFFFF_FF00 : floor_now + $urandom_range(0, 50);
        n = 0;
        while (n < count)
        begin
            it.message_tag = 16'($urandom);
            it.recurring   = 1'($urandom_range(0, 1));
            it.period_s    = $urandom;
            it.fire_at     = $urandom;
            it.job_id      = $urandom;
            it.now         = $urandom;
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                it.mode = MODE_UNUSED;
            end
            else if (r < 4 + add_pct)
            begin
                it.mode = MODE_ADD;
                it.message_tag = ($urandom_range(0, 9) == 0) ? 16'h0000
                                                              : 16'($urandom_range(1, 65535));
                if ($urandom_range(0, 3) != 0)
                    it.period_s = $urandom_range(0, 150);
                if ($urandom_range(0, 4) != 0)
                    it.fire_at = sat_add(t, $urandom_range(0, 400));
            end
            else if (r < 4 + add_pct + rm_pct)
            begin
                it.mode = MODE_REMOVE;
                if (table_mirror.job_total > 0 && $urandom_range(0, 3) != 0)
                    it.job_id = table_mirror.jobs[$urandom_range(0, table_mirror.job_total - 1)].id;
                else if ($urandom_range(0, 1) == 0)
                    it.job_id = table_mirror.next_id - $urandom_range(0, 3);
            end
            else
            begin
                it.mode = MODE_POLL;
                r = $urandom_range(0, 9);
                if (r == 1)
                begin
                    it.now = floor_now - 32'd1;
                end
                else if (r != 0)
                begin
                    t = sat_add(t, $urandom_range(0, 90));
                    it.now = t;
                end
            end
            send_item(it);
            if (it.mode != MODE_UNUSED)
                n++;
        end
    endtask

    initial
    begin
        table_mirror = new();
        burst_left   = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        item         = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        directed_items();

        write_regs(32'd0, 32'd0);
        random_items(45, 20, 64);
        write_regs(32'd30, 32'd1000);
        random_items(80, 8, 64);
        write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_items(40, 20, 64);
        write_regs($urandom, $urandom);
        random_items(45, 20, 64);
        write_regs(MIN_INTERVAL_RESET, TIME_FLOOR_RESET);
        random_items(40, 25, 64);

        drain();
        if (table_mirror.errors == 0 && table_mirror.awaited.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
design/tjt_pkg.sv
design/timed_job_table.sv
verif/timed_job_table_tb.sv
